/* src/lis_length_tracker_assert.svh */
// Assertion helpers for the tail tracker; clk and rst_n are taken from the including scope.
`ifndef LIS_LENGTH_TRACKER_ASSERT_SVH
`define LIS_LENGTH_TRACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define LIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lis_pkg.sv */
package lis_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 8;
  localparam int SLOT_W = 7;

  localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LEN_W + SLOT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_WRITE
  } lis_state_t;

  // Memory request from the search engine
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
  } lis_ram_req_t;

  // One result request
  typedef struct packed {
    logic              overflow;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
  } lis_result_t;

  // Engine status toward the top level
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } lis_status_t;

  // Midpoint of a search window, lo + (hi - lo) / 2
  function automatic logic [CNT_W-1:0] lis_mid(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[CNT_W:1];
  endfunction

endpackage

/* src/lis_ram.sv */
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/lis_ctrl.sv */
module lis_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_start,
  input  logic [lis_pkg::VAL_W-1:0]  in_value,
  output logic                       in_ready,
  output lis_pkg::lis_ram_req_t      ram_req,
  input  logic [lis_pkg::VAL_W-1:0]  rd_data,
  output logic                       res_valid,
  output lis_pkg::lis_result_t       res,
  input  logic                       res_ready,
  output lis_pkg::lis_status_t       status
);
  import lis_pkg::*;

  lis_state_t       state_r, state_nxt;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] item_cnt_r;
  logic [CNT_W-1:0] lo_r, hi_r, mid_r;
  logic [CNT_W-1:0] lo_c, hi_c, mid_c;
  logic             cmp_ge;
  logic             win_open;
  logic             replace, append;
  logic             accept;

  assign accept   = in_valid && in_ready;
  assign cmp_ge   = $signed(rd_data) >= $signed(val_r);
  assign replace  = lo_r < item_cnt_r;
  assign append   = !replace && (item_cnt_r < CNT_W'(DEPTH));

  // Narrow the search window with the tail read last cycle
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (state_r == ST_CMP) begin
      if (cmp_ge) begin
        hi_c = mid_r;
      end else begin
        lo_c = mid_r + CNT_W'(1);
      end
    end
    mid_c    = lis_mid(lo_c, hi_c);
    win_open = lo_c < hi_c;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PROBE;
      ST_PROBE,
      ST_CMP:   state_nxt = win_open ? ST_CMP : ST_WRITE;
      ST_WRITE: if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: memory request, result, new count
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    ram_req.rd_en   = ((state_r == ST_PROBE) || (state_r == ST_CMP)) && win_open;
    ram_req.rd_addr = mid_c[ADDR_W-1:0];
    ram_req.wr_en   = (state_r == ST_WRITE) && res_ready && (replace || append);
    ram_req.wr_addr = lo_r[ADDR_W-1:0];
    ram_req.wr_data = val_r;
    cnt_nxt         = append ? item_cnt_r + CNT_W'(1) : item_cnt_r;
    res_valid       = (state_r == ST_WRITE);
    res.length      = LEN_W'(cnt_nxt);
    res.slot        = (replace || append) ? SLOT_W'(lo_r) : '0;
    res.overflow    = !replace && !append;
    status.busy     = (state_r != ST_IDLE);
    status.count    = cnt_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_WRITE) && res_ready) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r      <= in_value;
      item_cnt_r <= in_start ? '0 : cnt_r;
      lo_r       <= '0;
      hi_r       <= in_start ? '0 : cnt_r;
    end else if ((state_r == ST_PROBE) || (state_r == ST_CMP)) begin
      lo_r  <= lo_c;
      hi_r  <= hi_c;
      mid_r <= mid_c;
    end
  end

endmodule

/* src/lis_length_tracker.sv */
// Longest strictly increasing subsequence length tracker.
// Input channel in_*: one request per value; in_tdata carries the signed
// 32-bit value, in_tuser set starts a new sequence (length cleared first).
// Output channel out_*: one result per request; out_tdata holds the length
// and the slot written, out_tuser flags an overflow (table full, value dropped).
// The tails table lives in a single-port-read memory. Each request runs a
// binary search, one memory read per cycle with the compare feeding the next
// address, then a write-back.
// A request's search makes at most floor(log2(count)) + 1 memory reads (none
// when the table is empty). A new request is accepted only once the last one
// has left its write-back; its result then shows on out_* from the output register.
// Results leave through an output register: the next request is accepted
// while a result waits. A stalled receiver holds the engine in its write
// cycle until the register frees.
// Reset (synchronous, active low) clears the length; the memory needs no
// clearing pass, since only tails written since the last start are read.
// The write-back and the next read never fall in the same cycle.
module lis_length_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lis_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic                             in_tuser,   // [0] start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lis_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] length, [14:8] slot, pad
  output logic                             out_tuser   // [0] overflow
);
  import lis_pkg::*;

  `include "lis_length_tracker_assert.svh"

  lis_ram_req_t     ram_req;
  logic [VAL_W-1:0] rd_data;
  logic             res_valid, res_ready;
  lis_result_t      res;
  lis_status_t      status;
  logic             out_valid_r;
  lis_result_t      out_res_r;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_start  (in_tuser),
    .in_value  (in_tdata[VAL_W-1:0]),
    .in_ready  (in_tready),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .status    (status)
  );

  lis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_tails (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  // Hold the result until the receiver takes it
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.slot, out_res_r.length});
  assign out_tuser  = out_res_r.overflow;

  `LIS_ASSERT_IMPL(a_count_bound, 1'b1,
                   status.count <= CNT_W'(DEPTH), "tail count above depth")
  `LIS_ASSERT_IMPL(a_ovf_full, out_tvalid && out_tuser,
                   out_tdata[LEN_W-1:0] == LEN_W'(DEPTH), "overflow without full table")
  `LIS_ASSERT_IMPL(a_no_rw_overlap, ram_req.wr_en,
                   !ram_req.rd_en, "tail read and write-back overlap")
  `LIS_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready,
                   status.busy && !in_tready, "request taken while busy")

endmodule
